[rtl/smmt_pkg.sv]
`timescale 1ns / 1ps

package smmt_pkg;

  localparam int SAMPLE_W = 32;
  localparam int CNT_W    = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  // Control that the top level hands to each cell chain
  typedef struct packed {
    logic upd;   // insert the sample this cycle
    cnt_t held;  // entries valid before the insert
    cnt_t pick;  // position to read out after the insert
  } chain_ctl_t;

endpackage

[rtl/soft_min_max_tracker_top.sv]
`timescale 1ns / 1ps

// Running soft minimum / soft maximum tracker. Each item taken without a keep_count write
// yields one result item in the cycle after, and a new item is taken every cycle while the
// output is not stalled. Two sorted chains of MAX_KEEP cells hold the keep_count smallest
// and the keep_count largest samples; one insert is a compare in every cell plus a shift
// by one cell, followed by a read of the cell at the fill position. Writing keep_count
// empties both chains; keep_count 0 acts as 1 and values above MAX_KEEP act as MAX_KEEP.
module soft_min_max_tracker_top #(
  parameter int MAX_KEEP = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  smmt_pkg::cnt_t      cfg_keep_count,
  input  logic                in_valid,
  output logic                in_stall,
  input  smmt_pkg::sample_t   in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output smmt_pkg::sample_t   out_soft_min,
  output smmt_pkg::sample_t   out_soft_max,
  output smmt_pkg::cnt_t      out_fill_count
);
  import smmt_pkg::*;

  cnt_t       keep_r;
  cnt_t       held_r;
  cnt_t       held_nxt;
  cnt_t       limit;
  logic       accept;
  logic       out_valid_r;
  sample_t    soft_min_r;
  sample_t    soft_max_r;
  cnt_t       fill_r;
  chain_ctl_t ctl;
  sample_t    low_pick;
  sample_t    high_pick;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (keep_r == '0) begin
      limit = CNT_W'(1);
    end else if (32'(keep_r) > 32'(MAX_KEEP)) begin
      limit = CNT_W'(MAX_KEEP);
    end else begin
      limit = keep_r;
    end
  end

  assign held_nxt = (held_r < limit) ? held_r + CNT_W'(1) : held_r;

  assign ctl.upd  = accept && !cfg_wr_en;
  assign ctl.held = held_r;
  assign ctl.pick = held_nxt - CNT_W'(1);

  smmt_chain #(.DEPTH(MAX_KEEP)) u_low (
    .clk      (clk),
    .ctl      (ctl),
    .s        (in_sample),
    .pick_val (low_pick)
  );

  // Bitwise inversion reverses signed order, so the same ascending chain keeps the largest
  smmt_chain #(.DEPTH(MAX_KEEP)) u_high (
    .clk      (clk),
    .ctl      (ctl),
    .s        (~in_sample),
    .pick_val (high_pick)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r      <= CNT_W'(1);
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        keep_r <= cfg_keep_count;
        held_r <= '0;
      end else if (accept) begin
        held_r <= held_nxt;
      end
      if (ctl.upd) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      soft_min_r <= low_pick;
      soft_max_r <= ~high_pick;
      fill_r     <= held_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_soft_min   = soft_min_r;
  assign out_soft_max   = soft_max_r;
  assign out_fill_count = fill_r;

endmodule

[rtl/smmt_cell.sv]
`timescale 1ns / 1ps

module smmt_cell (
  input  logic             clk,
  input  logic             upd,
  input  smmt_pkg::sample_t s,
  input  logic             valid,
  input  logic             left_goes,
  input  smmt_pkg::sample_t left_val,
  output logic             goes,
  output smmt_pkg::sample_t val,
  output smmt_pkg::sample_t val_nxt
);
  import smmt_pkg::*;

  sample_t val_r;

  // The sample sits at or before this cell when the cell is empty or holds a larger value
  assign goes = !valid || (s < val_r);

  always_comb begin
    if (left_goes) begin
      val_nxt = left_val;
    end else if (goes) begin
      val_nxt = s;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

[rtl/smmt_chain.sv]
`timescale 1ns / 1ps

module smmt_chain #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  smmt_pkg::chain_ctl_t ctl,
  input  smmt_pkg::sample_t    s,
  output smmt_pkg::sample_t    pick_val
);
  import smmt_pkg::*;

  sample_t cur   [DEPTH];
  sample_t nxt   [DEPTH];
  logic    goes  [DEPTH];
  logic    valid [DEPTH];

  // Ascending order: cell 0 holds the smallest kept value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic    lg;
    sample_t lv;

    assign valid[i] = (32'(i) < 32'(ctl.held));

    if (i == 0) begin : g_head
      assign lg = 1'b0;
      assign lv = s;
    end else begin : g_link
      assign lg = goes[i-1];
      assign lv = cur[i-1];
    end

    smmt_cell u_cell (
      .clk       (clk),
      .upd       (ctl.upd),
      .s         (s),
      .valid     (valid[i]),
      .left_goes (lg),
      .left_val  (lv),
      .goes      (goes[i]),
      .val       (cur[i]),
      .val_nxt   (nxt[i])
    );
  end

  always_comb begin
    pick_val = nxt[0];
    for (int i = 0; i < DEPTH; i++) begin
      if (32'(i) == 32'(ctl.pick)) begin
        pick_val = nxt[i];
      end
    end
  end

endmodule

[dv/tb_soft_min_max_tracker_top.sv]
`timescale 1ns / 1ps

module tb_soft_min_max_tracker_top;
  import smmt_pkg::*;

  localparam int MAX_KEEP     = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int SHOW_ERRORS  = 10;

  typedef struct {
    sample_t soft_min;
    sample_t soft_max;
    cnt_t    fill;
  } extremes_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cfg_wr_en = 1'b0;
  cnt_t    cfg_keep_count = '0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_sample = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_soft_min;
  sample_t out_soft_max;
  cnt_t    out_fill_count;

  soft_min_max_tracker_top #(.MAX_KEEP(MAX_KEEP)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_keep_count (cfg_keep_count),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_soft_min   (out_soft_min),
    .out_soft_max   (out_soft_max),
    .out_fill_count (out_fill_count)
  );

  always #1 clk = ~clk;

  // Tracker copy used for prediction
  sample_t   low_kept [MAX_KEEP];
  sample_t   high_kept [MAX_KEEP];
  int        kept_n = 0;
  cnt_t      keep_reg = 5'd1;

  sample_t   sample_queue [$];
  extremes_t extremes_queue [$];

  int        errors = 0;
  int        idle_cycles = 0;
  int        tx_gap = 0;
  int        rx_gap = 0;
  logic      no_gaps = 1'b0;
  logic      sender_hold = 1'b0;
  sample_t   tx_next;

  function automatic void track_sample(sample_t s);
    int lim;
    int lo;
    int hi;
    extremes_t e;
    lim = (keep_reg < 1) ? 1 : ((keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg));
    if (kept_n > lim) kept_n = lim;
    if (kept_n < lim) begin
      low_kept[kept_n]  = s;
      high_kept[kept_n] = s;
      kept_n++;
    end else begin
      lo = 0;
      hi = 0;
      for (int i = 1; i < kept_n; i++) begin
        if (low_kept[i] > low_kept[lo]) lo = i;
        if (high_kept[i] < high_kept[hi]) hi = i;
      end
      // equal samples never displace a kept value
      if (s < low_kept[lo]) low_kept[lo] = s;
      if (s > high_kept[hi]) high_kept[hi] = s;
    end
    e.soft_min = low_kept[0];
    e.soft_max = high_kept[0];
    for (int i = 1; i < kept_n; i++) begin
      if (low_kept[i] > e.soft_min) e.soft_min = low_kept[i];
      if (high_kept[i] < e.soft_max) e.soft_max = high_kept[i];
    end
    e.fill = cnt_t'(kept_n);
    extremes_queue.push_back(e);
  endfunction

  // Driver: present the next pending item once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (!no_gaps && tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (!no_gaps && $urandom_range(0, 15) == 0) begin
        in_valid <= 1'b0;
        tx_gap   <= $urandom_range(0, 12);
      end else if (!sender_hold && sample_queue.size() != 0) begin
        tx_next = sample_queue.pop_front();
        in_valid  <= 1'b1;
        in_sample <= tx_next;
        track_sample(tx_next);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result, stall in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (extremes_queue.size() == 0) begin
          errors++;
          if (errors <= SHOW_ERRORS)
            $display("result with nothing expected: min %0d max %0d fill %0d",
                     out_soft_min, out_soft_max, out_fill_count);
        end else begin
          extremes_t e;
          e = extremes_queue.pop_front();
          if (e.soft_min !== out_soft_min || e.soft_max !== out_soft_max ||
              e.fill !== out_fill_count) begin
            errors++;
            if (errors <= SHOW_ERRORS)
              $display("mismatch: expected min %0d max %0d fill %0d, got min %0d max %0d fill %0d",
                       e.soft_min, e.soft_max, e.fill,
                       out_soft_min, out_soft_max, out_fill_count);
          end
        end
      end
      if (!no_gaps && rx_gap > 0) begin
        out_stall <= 1'b1;
        rx_gap    <= rx_gap - 1;
      end else if (!no_gaps && $urandom_range(0, 15) == 0) begin
        out_stall <= 1'b1;
        rx_gap    <= $urandom_range(0, 12);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles with work outstanding and no handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (sample_queue.size() == 0 && extremes_queue.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** soft_min_max_tracker_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid || extremes_queue.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_keep(cnt_t v);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_wr_en      <= 1'b1;
    cfg_keep_count <= v;
    keep_reg = v;
    kept_n   = 0;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic sample_t pick_sample(int mode);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return '0;
        default: return '1;
      endcase
    end
    if (mode == 1 || (mode == 2 && r < 5))
      return sample_t'(int'($urandom_range(0, 16)) - 8);
    return sample_t'($urandom);
  endfunction

  initial begin
    cnt_t keep_plan [12];
    int   n;
    keep_plan = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd0, 5'd2, 5'd8, 5'd3,
                  5'd16, 5'd5, 5'd12, 5'd31};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Keep count from reset: single-entry stores, extremes and repeats
    sample_queue.push_back(32'sh7FFF_FFFF);
    sample_queue.push_back(32'sh8000_0000);
    sample_queue.push_back('0);
    sample_queue.push_back('1);
    sample_queue.push_back('1);
    sample_queue.push_back(32'sd5);
    wait_drained();

    // Fill with equal samples, then probe both replacement sides
    write_keep(5'd3);
    sample_queue.push_back(32'sd10);
    sample_queue.push_back(32'sd10);
    sample_queue.push_back(32'sd10);
    sample_queue.push_back(32'sd10);
    sample_queue.push_back(32'sd5);
    sample_queue.push_back(32'sd20);
    sample_queue.push_back(32'sh8000_0000);
    sample_queue.push_back(32'sh7FFF_FFFF);
    sample_queue.push_back('1);
    sample_queue.push_back(32'sd1);

    // Zero acts as one
    write_keep(5'd0);
    sample_queue.push_back(32'sd7);
    sample_queue.push_back(32'sh8000_0000);
    sample_queue.push_back(32'sd7);

    for (int p = 0; p < 12; p++) begin
      if (p >= 7 && p <= 8) keep_plan[p] = cnt_t'($urandom_range(0, 31));
      no_gaps = (p >= 10);
      write_keep(keep_plan[p]);
      n = $urandom_range(70, 150);
      for (int i = 0; i < n; i++) sample_queue.push_back(pick_sample(p % 3));
      if (p == 4) begin
        while (sample_queue.size() > n / 2) @(negedge clk);
        // hold the sender until the block has nothing in flight
        sender_hold = 1'b1;
        while (in_valid || extremes_queue.size() != 0) @(negedge clk);
        sender_hold = 1'b0;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && extremes_queue.size() == 0) begin
      $display("** soft_min_max_tracker_top: PASSED **");
    end else begin
      $display("** soft_min_max_tracker_top: FAILED **");
    end
    $finish;
  end

endmodule
